[sv/hill_cipher_decrypt_2x2_assert.svh]
// Assertion macros used by the checker file.
`ifndef HILL_CIPHER_DECRYPT_2X2_ASSERT_SVH
`define HILL_CIPHER_DECRYPT_2X2_ASSERT_SVH

// Implication within the same cycle; expects clk and rst_n in scope.
`define HCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle.
`define HCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/hcd_pkg.sv]
package hcd_pkg;

    localparam int CHAR_W     = 8;
    localparam int PLAIN_W    = 7;
    localparam int LETTER_W   = 5;
    localparam int KEY_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [LETTER_W-1:0] MODULUS  = 5'd26;
    localparam logic [10:0]         MOD_SQ   = 11'd676;
    localparam logic [CHAR_W-1:0]   UPPER_A  = 8'd65;
    localparam logic [CHAR_W-1:0]   LOWER_A  = 8'd97;
    localparam logic [CHAR_W-1:0]   ALPHA_N  = 8'd26;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_R0_C0,
        REG_KEY_R0_C1,
        REG_KEY_R1_C0,
        REG_KEY_R1_C1
    } cfg_reg_t;

    // Key terms used by the datapath: adjugate entries and det inverse.
    typedef struct packed {
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] nb;
        logic [KEY_W-1:0] nc;
        logic [KEY_W-1:0] d;
        logic [KEY_W-1:0] dinv;
        logic             err;
    } key_t;

    typedef struct packed {
        logic [LETTER_W-1:0] p0;
        logic [LETTER_W-1:0] p1;
        logic                err;
    } pair_t;

    function automatic logic [9:0] mul5(logic [4:0] x, logic [4:0] y);
        logic [9:0] xe;
        logic [9:0] ye;
        xe = {5'd0, x};
        ye = {5'd0, y};
        return xe * ye;
    endfunction

    // x mod 26 for an 11-bit x; folds with 32 = 6 (mod 26).
    function automatic logic [4:0] mod26_11(logic [10:0] x);
        logic [8:0] y1;
        logic [6:0] y2;
        logic [5:0] y3;
        y1 = 9'({x[10:5], 2'b00}) + 9'({x[10:5], 1'b0}) + 9'(x[4:0]);
        y2 = 7'({y1[8:5], 2'b00}) + 7'({y1[8:5], 1'b0}) + 7'(y1[4:0]);
        y3 = 6'({y2[6:5], 2'b00}) + 6'({y2[6:5], 1'b0}) + 6'(y2[4:0]);
        if (y3 >= 6'(MODULUS))
            y3 = y3 - 6'(MODULUS);
        return y3[4:0];
    endfunction

    // Inverse mod 26; zero when none exists.
    function automatic logic [4:0] inv26(logic [4:0] v);
        logic [4:0] r;
        case (v)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

[sv/hcd_key_unit.sv]
module hcd_key_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hcd_pkg::KEY_W-1:0]     cfg_data,
    output hcd_pkg::key_t                 key
);
    import hcd_pkg::*;

    logic [KEY_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [KEY_W-1:0] a_next, b_next, c_next, d_next;
    logic [KEY_W-1:0] dinv_reg, dinv_next;
    logic             err_reg, err_next;
    logic [KEY_W-1:0] wr_val;
    logic [10:0]      det_raw;

    // values 26..31 fold back into range on write
    assign wr_val = (cfg_data >= MODULUS) ? (cfg_data - MODULUS) : cfg_data;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_R0_C0: a_next = wr_val;
                REG_KEY_R0_C1: b_next = wr_val;
                REG_KEY_R1_C0: c_next = wr_val;
                REG_KEY_R1_C1: d_next = wr_val;
            endcase
        end
    end

    assign det_raw   = {1'b0, mul5(a_reg, d_reg)} + MOD_SQ - {1'b0, mul5(b_reg, c_reg)};
    assign dinv_next = inv26(mod26_11(det_raw));
    assign err_next  = (dinv_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= 5'd1;
            b_reg    <= 5'd0;
            c_reg    <= 5'd0;
            d_reg    <= 5'd1;
            dinv_reg <= 5'd1;
            err_reg  <= 1'b0;
        end
        else
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            d_reg    <= d_next;
            dinv_reg <= dinv_next;
            err_reg  <= err_next;
        end
    end

    assign key.a    = a_reg;
    assign key.nb   = (b_reg == '0) ? '0 : (MODULUS - b_reg);
    assign key.nc   = (c_reg == '0) ? '0 : (MODULUS - c_reg);
    assign key.d    = d_reg;
    assign key.dinv = dinv_reg;
    assign key.err  = err_reg;

endmodule

[sv/hcd_pair_fifo.sv]
module hcd_pair_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  hcd_pkg::pair_t                 push_data,
    output logic [hcd_pkg::FIFO_CNT_W-1:0] count,
    output logic                           plain_valid,
    input  logic                           plain_ready,
    output logic [hcd_pkg::PLAIN_W-1:0]    plain_char,
    output logic                           key_error,
    output logic                           pair_last
);
    import hcd_pkg::*;

    pair_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  half_reg, half_next;
    logic                  take, pop;
    pair_t                 head;
    logic [LETTER_W-1:0]   letter;

    assign head        = mem_reg[rd_ptr_reg];
    assign plain_valid = (count_reg != '0);
    assign take        = plain_valid && plain_ready;
    assign pop         = take && half_reg;

    // each entry goes out as two requests, first letter then second
    always_comb
    begin
        half_next   = half_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (take)
            half_next = !half_reg;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        count_next = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            half_reg   <= half_next;
        end
    end

    assign letter     = half_reg ? head.p1 : head.p0;
    assign plain_char = PLAIN_W'(LOWER_A) + PLAIN_W'(letter);
    assign key_error  = head.err;
    assign pair_last  = half_reg;
    assign count      = count_reg;

endmodule

[sv/hill_cipher_decrypt_2x2.sv]
// 2x2 Hill cipher decryptor, mod 26. Takes one ASCII byte per cycle on the
// char channel; letters of either case count, every other byte is dropped.
// Letters are paired in order, and each pair yields two lowercase plaintext
// requests (pair_last low, then high) once the pair has passed the s1, s2
// and s3 registers into the output queue. Throughput is one character per
// cycle and one result per cycle while plain_ready is high; the input stalls
// only when the four-pair output queue plus the pairs in the three datapath
// stages is full. Key writes are registered, then dinv from them; a key whose
// determinant has no inverse mod 26 gives key_error and plain_char 'a' for both.
module hill_cipher_decrypt_2x2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hcd_pkg::KEY_W-1:0]     cfg_data,
    input  logic                          char_valid,
    output logic                          char_ready,
    input  logic [hcd_pkg::CHAR_W-1:0]    char_in,
    output logic                          plain_valid,
    input  logic                          plain_ready,
    output logic [hcd_pkg::PLAIN_W-1:0]   plain_char,
    output logic                          key_error,
    output logic                          pair_last
);
    import hcd_pkg::*;

    key_t                  key;
    logic                  take;
    logic                  is_upper, is_lower, is_letter;
    logic [LETTER_W-1:0]   letter;

    logic [LETTER_W-1:0]   held_reg, held_next;
    logic                  have_held_reg, have_held_next;

    logic                  s1_valid_reg, s1_valid_next;
    logic [LETTER_W-1:0]   s1_c0_reg, s1_c1_reg;
    logic                  s2_valid_reg;
    logic [LETTER_W-1:0]   s2_q0_reg, s2_q1_reg;
    logic [LETTER_W-1:0]   q0_next, q1_next;
    logic                  s3_valid_reg;
    pair_t                 s3_pair_reg, s3_pair_next;

    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W-1:0] committed;

    hcd_key_unit u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // queue slots already claimed by pairs in flight
    assign committed  = fifo_count + FIFO_CNT_W'(s1_valid_reg) + FIFO_CNT_W'(s2_valid_reg)
                      + FIFO_CNT_W'(s3_valid_reg);
    assign char_ready = (committed < FIFO_CNT_W'(FIFO_DEPTH));
    assign take       = char_valid && char_ready;

    assign is_upper  = (char_in >= UPPER_A) && (char_in < UPPER_A + ALPHA_N);
    assign is_lower  = (char_in >= LOWER_A) && (char_in < LOWER_A + ALPHA_N);
    assign is_letter = is_upper || is_lower;
    assign letter    = is_upper ? LETTER_W'(char_in - UPPER_A) : LETTER_W'(char_in - LOWER_A);

    always_comb
    begin
        held_next      = held_reg;
        have_held_next = have_held_reg;
        s1_valid_next  = 1'b0;
        if (take && is_letter)
        begin
            if (!have_held_reg)
            begin
                held_next      = letter;
                have_held_next = 1'b1;
            end
            else
            begin
                held_next      = '0;
                have_held_next = 1'b0;
                s1_valid_next  = 1'b1;
            end
        end
    end

    // adjugate times ciphertext pair
    assign q0_next = mod26_11({1'b0, mul5(key.d, s1_c0_reg)} + {1'b0, mul5(key.nb, s1_c1_reg)});
    assign q1_next = mod26_11({1'b0, mul5(key.nc, s1_c0_reg)} + {1'b0, mul5(key.a, s1_c1_reg)});

    // scale by det inverse; singular key forces 'a'
    always_comb
    begin
        s3_pair_next.err = key.err;
        s3_pair_next.p0  = key.err ? '0 : mod26_11({1'b0, mul5(s2_q0_reg, key.dinv)});
        s3_pair_next.p1  = key.err ? '0 : mod26_11({1'b0, mul5(s2_q1_reg, key.dinv)});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            have_held_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            have_held_reg <= have_held_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_c0_reg   <= held_reg;
        s1_c1_reg   <= letter;
        s2_q0_reg   <= q0_next;
        s2_q1_reg   <= q1_next;
        s3_pair_reg <= s3_pair_next;
    end

    hcd_pair_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (s3_valid_reg),
        .push_data   (s3_pair_reg),
        .count       (fifo_count),
        .plain_valid (plain_valid),
        .plain_ready (plain_ready),
        .plain_char  (plain_char),
        .key_error   (key_error),
        .pair_last   (pair_last)
    );

endmodule

[sv/hcd_checker.sv]
`include "hill_cipher_decrypt_2x2_assert.svh"

module hcd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_we,
    input logic [hcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [hcd_pkg::KEY_W-1:0]     cfg_data,
    input logic                          char_valid,
    input logic                          char_ready,
    input logic [hcd_pkg::CHAR_W-1:0]    char_in,
    input logic                          plain_valid,
    input logic                          plain_ready,
    input logic [hcd_pkg::PLAIN_W-1:0]   plain_char,
    input logic                          key_error,
    input logic                          pair_last
);
    import hcd_pkg::*;

    `HCD_ASSERT_IMP(a_char_range, plain_valid, (plain_char >= PLAIN_W'(LOWER_A)) && (plain_char <= PLAIN_W'(LOWER_A + ALPHA_N - 8'd1)), "plain_char not a lowercase letter")

    `HCD_ASSERT_IMP(a_err_char, plain_valid && key_error, plain_char == PLAIN_W'(LOWER_A), "singular key must give 'a'")

    `HCD_ASSERT_NEXT(a_hold, plain_valid && !plain_ready, plain_valid && $stable(plain_char) && $stable(key_error) && $stable(pair_last), "stalled result changed")

    // second letter of a pair follows right behind the first
    `HCD_ASSERT_NEXT(a_pair_second, plain_valid && plain_ready && !pair_last, plain_valid && pair_last && $stable(key_error), "second letter of pair missing")

endmodule

bind hill_cipher_decrypt_2x2 hcd_checker u_hcd_checker (.*);
